### rtl/core/spmq_pkg.sv
// Package of shared types and constants for the strict priority message queue.
package spmq_pkg;

  localparam int QueueCount = 4;
  localparam int QueueDepth = 512;

  typedef enum logic [1:0] {
    KindPost  = 2'd0,
    KindGet   = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StatPosted    = 3'd0,
    StatFull      = 3'd1,
    StatBadQueue  = 3'd2,
    StatDelivered = 3'd3,
    StatEmpty     = 3'd4,
    StatCleared   = 3'd5
  } status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StResp = 1'b1
  } state_e;

  typedef enum logic {
    CfgTouch = 1'b0,
    CfgKey   = 1'b1
  } cfg_idx_e;

endpackage

### rtl/core/spmq_if.sv
// Handshake channels for request items and result items of the message queue.
interface spmq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  queue_select;
  logic [31:0] message_code;
  logic [31:0] first_param;
  logic [31:0] second_param;
  logic [31:0] third_param;

  modport source (output valid, kind, queue_select, message_code, first_param,
                  second_param, third_param, input ready);
  modport sink (input valid, kind, queue_select, message_code, first_param,
                second_param, third_param, output ready);
endinterface

interface spmq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  source_queue;
  logic [31:0] out_message_code;
  logic [31:0] out_first_param;
  logic [31:0] out_second_param;
  logic [31:0] out_third_param;

  modport source (output valid, status, source_queue, out_message_code, out_first_param,
                  out_second_param, out_third_param, input ready);
  modport sink (input valid, status, source_queue, out_message_code, out_first_param,
                out_second_param, out_third_param, output ready);
endinterface

### rtl/core/strict_priority_multi_queue_core.sv
// Top level of the strict priority message queue store.
// For each request item, in the cycle it is accepted the block picks the target queue,
// updates its pointer and fill count through one shared pointer and count unit and makes
// the single access to the message memory; then the registered result, with the read data
// for a get, moves into the output register once it is empty or read. A new item is taken
// once the previous result has entered the output register, so a stalled output holds the
// block after one item. The message memory has QUEUE_COUNT * QUEUE_DEPTH entries of 128 bits
// and needs no clearing after reset, since only entries counted as filled are ever read.
module strict_priority_multi_queue_core #(
  parameter int QUEUE_COUNT = spmq_pkg::QueueCount,
  parameter int QUEUE_DEPTH = spmq_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spmq_req_if.sink              req_i,
  spmq_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  spmq_pkg::cfg_idx_e    cfg_idx_i,
  input  logic [1:0]            cfg_data_i
);
  import spmq_pkg::*;

  localparam int QW = $clog2(QUEUE_COUNT);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MD = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int AW = $clog2(MD);

  state_e          state_q, state_d;
  logic [1:0]      touch_q, key_q;
  logic [PW-1:0]   wptr_q [QUEUE_COUNT];
  logic [PW-1:0]   rptr_q [QUEUE_COUNT];
  logic [CW-1:0]   cnt_q  [QUEUE_COUNT];
  logic [127:0]    mem    [MD];
  logic [127:0]    rd_q;

  status_e         res_status_q, res_status_d;
  logic [2:0]      res_src_q, res_src_d;

  logic            out_valid_q, out_valid_d;
  status_e         out_status_q;
  logic [2:0]      out_src_q;
  logic [127:0]    out_data_q;
  logic            out_load;

  logic            accept;
  logic [QW-1:0]   sel;
  logic [QW-1:0]   win;
  logic            any;
  logic            is_post;
  logic            do_write, do_read, do_clear;
  logic [PW-1:0]   ptr_sel, ptr_nxt;
  logic [CW-1:0]   cnt_sel, cnt_nxt;
  logic [AW-1:0]   addr;

  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle);

  always_comb begin
    win = '0;
    any = 1'b0;
    for (int i = QUEUE_COUNT - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        win = QW'(i);
        any = 1'b1;
      end
    end
  end

  assign is_post = (req_i.kind == KindPost);
  assign sel     = is_post ? req_i.queue_select[QW-1:0] : win;
  assign ptr_sel = is_post ? wptr_q[sel] : rptr_q[sel];
  assign cnt_sel = cnt_q[sel];
  assign ptr_nxt = (ptr_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
  assign cnt_nxt = is_post ? cnt_sel + 1'b1 : cnt_sel - 1'b1;
  assign addr    = AW'(AW'(sel) * AW'(QUEUE_DEPTH)) + AW'(ptr_sel);

  always_comb begin
    do_write     = 1'b0;
    do_read      = 1'b0;
    do_clear     = 1'b0;
    res_status_d = StatBadQueue;
    res_src_d    = '0;
    unique case (req_i.kind)
      KindPost: begin
        if ({1'b0, req_i.queue_select} >= 4'(QUEUE_COUNT)) begin
          res_status_d = StatBadQueue;
        end else if (cnt_sel == CW'(QUEUE_DEPTH)) begin
          res_status_d = StatFull;
        end else begin
          res_status_d = StatPosted;
          do_write     = accept;
        end
      end
      KindGet: begin
        if (any) begin
          res_status_d = StatDelivered;
          res_src_d    = 3'(win);
          do_read      = accept;
        end else begin
          res_status_d = StatEmpty;
          res_src_d    = 3'(QUEUE_COUNT);
        end
      end
      KindClear: begin
        res_status_d = StatCleared;
        do_clear     = accept;
      end
      default: begin
        res_status_d = StatBadQueue;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      touch_q     <= 2'd0;
      key_q       <= 2'd1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTouch: touch_q <= cfg_data_i;
          CfgKey:   key_q   <= cfg_data_i;
          default:  touch_q <= touch_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        wptr_q[i] <= '0;
        rptr_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (do_clear) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        if ((4'(i) == {2'b00, touch_q}) || (4'(i) == {2'b00, key_q})) begin
          wptr_q[i] <= '0;
          rptr_q[i] <= '0;
          cnt_q[i]  <= '0;
        end
      end
    end else if (do_write) begin
      wptr_q[sel] <= ptr_nxt;
      cnt_q[sel]  <= cnt_nxt;
    end else if (do_read) begin
      rptr_q[sel] <= ptr_nxt;
      cnt_q[sel]  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[addr] <= {req_i.message_code, req_i.first_param, req_i.second_param,
                    req_i.third_param};
    end
    if (do_read) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= res_status_d;
      res_src_q    <= res_src_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_src_q    <= res_src_q;
      out_data_q   <= (res_status_q == StatDelivered) ? rd_q : '0;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.source_queue     = out_src_q;
  assign rsp_o.out_message_code = out_data_q[127:96];
  assign rsp_o.out_first_param  = out_data_q[95:64];
  assign rsp_o.out_second_param = out_data_q[63:32];
  assign rsp_o.out_third_param  = out_data_q[31:0];

endmodule

### rtl/core/spmq_checker.sv
// Port level checks of the strict priority message queue and their binding to the top level.
module spmq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [2:0]  source_queue_i,
  input logic [31:0] code_i,
  input logic [31:0] third_i
);
  import spmq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(code_i))
    else $error("Result item changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Request item accepted while the previous one was in progress.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= StatCleared)
    else $error("Result status out of range.");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != StatDelivered) |-> (code_i == '0) && (third_i == '0))
    else $error("Non-delivery result carries message words.");

  a_src_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != StatDelivered) && (status_i != StatEmpty)
      |-> source_queue_i == '0)
    else $error("Source queue set on a result without a queue.");

endmodule

bind strict_priority_multi_queue_core spmq_checker u_spmq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .source_queue_i (rsp_o.source_queue),
  .code_i         (rsp_o.out_message_code),
  .third_i        (rsp_o.out_third_param)
);
